@@ rtl/cec_pkg.sv @@
// shared constants for the complex envelope clipper
package cec_pkg;

  localparam int GAIN_BITS = 16;
  localparam int GAIN_FRAC = 12;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4096;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RUN_ENABLE = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINEAR_GAIN = 1'd1;

  // handshake toward the next cell
  typedef struct packed {
    logic valid;
  } hs_t;

endpackage

@@ rtl/cec_sqrt_cell.sv @@
// one bit of the pipelined restoring square root
module cec_sqrt_cell
  import cec_pkg::*;
#(
  parameter int W = 16,
  parameter int K = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  hs_t            up,
  output logic           up_ready,
  input  logic [2*W-1:0] x_in,
  input  logic [2*W-1:0] r_in,
  input  logic [2*W-1:0] side_in,
  output hs_t            dn,
  input  logic           dn_ready,
  output logic [2*W-1:0] x_out,
  output logic [2*W-1:0] r_out,
  output logic [2*W-1:0] side_out
);

  logic           valid;
  logic [2*W-1:0] bit_val;
  logic [2*W-1:0] trial;
  logic           take;

  assign up_ready = !valid || dn_ready;
  assign dn.valid = valid;
  assign bit_val  = (2*W)'(1) << (2*K);
  assign trial    = r_in + bit_val;
  assign take     = x_in >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up_ready) begin
      side_out <= side_in;
      if (take) begin
        x_out <= x_in - trial;
        r_out <= (r_in >> 1) + bit_val;
      end else begin
        x_out <= x_in;
        r_out <= r_in >> 1;
      end
    end
  end

endmodule

@@ rtl/cec_div_cell.sv @@
// one quotient bit of the pipelined restoring divider
module cec_div_cell
  import cec_pkg::*;
#(
  parameter int W = 16,
  parameter int K = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  hs_t            up,
  output logic           up_ready,
  input  logic [2*W:0]   rem_in,
  input  logic [W:0]     q_in,
  input  logic [W-1:0]   mag_in,
  input  logic [2*W-1:0] side_in,
  output hs_t            dn,
  input  logic           dn_ready,
  output logic [2*W:0]   rem_out,
  output logic [W:0]     q_out,
  output logic [W-1:0]   mag_out,
  output logic [2*W-1:0] side_out
);

  logic         valid;
  logic [2*W:0] divisor;
  logic         take;

  assign up_ready = !valid || dn_ready;
  assign dn.valid = valid;
  assign divisor  = (2*W+1)'(mag_in) << K;
  assign take     = rem_in >= divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up_ready) begin
      mag_out  <= mag_in;
      side_out <= side_in;
      rem_out  <= take ? rem_in - divisor : rem_in;
      q_out    <= q_in | ((W+1)'(take) << K);
    end
  end

endmodule

@@ rtl/complex_envelope_clipper.sv @@
// top level of the complex envelope clipper
//
// Stream in: s_tdata carries one complex sample word (sample_i low, sample_q
// above it). Stream out: m_tdata carries out_i low, out_q above it. Words are
// taken when tvalid and tready are both high on a side.
// With run_enable set, the magnitude is formed by a row of square-root cells
// (one result bit per cell), a row of divider cells (one quotient bit per
// cell) forms I/mag, and the output stage picks the clipped or gain-scaled I
// value, saturates it and drives Q to zero. With run_enable clear, I and Q pass unchanged.
// The pipeline is one squaring stage, SAMPLE_BITS root cells, SAMPLE_BITS+1
// divider cells and one output register. One word is accepted per cycle while
// s_tready is high. Each cell holds its word until the next one frees, so when
// m_tready is low the row fills up and s_tready drops only once every stage is
// occupied.
// Reset empties the pipeline and sets run_enable to 0 and linear_gain to
// unity (4096). Write registers through cfg_we/cfg_index/cfg_data while idle.
module complex_envelope_clipper
  import cec_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // sample_i, sample_q
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_i, out_q
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
  input  logic                              cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]         cfg_index,
  input  logic [GAIN_BITS-1:0]              cfg_data
);

  localparam int W  = SAMPLE_BITS;
  localparam int F  = W - 1;
  localparam int TW = ((2*W+7)/8)*8;
  localparam int MW = W + GAIN_BITS + 1;

  logic                 run_enable;
  logic [GAIN_BITS-1:0] linear_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable  <= 1'b0;
      linear_gain <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RUN_ENABLE:  run_enable  <= cfg_data[0];
        REG_LINEAR_GAIN: linear_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // squaring stage
  logic [W-1:0]   in_i, in_q, in_ai, in_aq;
  logic           sq_valid;
  logic [2*W-1:0] sq_mag2;
  logic [2*W-1:0] sq_side;

  hs_t            sc_hs    [W+1];
  logic           sc_ready [W+1];
  logic [2*W-1:0] sc_x     [W+1];
  logic [2*W-1:0] sc_r     [W+1];
  logic [2*W-1:0] sc_side  [W+1];

  assign in_i  = s_tdata[W-1:0];
  assign in_q  = s_tdata[2*W-1:W];
  assign in_ai = in_i[W-1] ? ~in_i + 1'b1 : in_i;
  assign in_aq = in_q[W-1] ? ~in_q + 1'b1 : in_q;

  assign s_tready = !sq_valid || sc_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (s_tready) begin
      sq_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sq_mag2 <= (2*W)'(in_ai) * (2*W)'(in_ai) + (2*W)'(in_aq) * (2*W)'(in_aq);
      sq_side <= {in_q, in_i};
    end
  end

  assign sc_hs[0].valid = sq_valid;
  assign sc_x[0]        = sq_mag2;
  assign sc_r[0]        = '0;
  assign sc_side[0]     = sq_side;

  for (genvar j = 0; j < W; j++) begin : g_sqrt
    cec_sqrt_cell #(.W(W), .K(W-1-j)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up       (sc_hs[j]),
      .up_ready (sc_ready[j]),
      .x_in     (sc_x[j]),
      .r_in     (sc_r[j]),
      .side_in  (sc_side[j]),
      .dn       (sc_hs[j+1]),
      .dn_ready (sc_ready[j+1]),
      .x_out    (sc_x[j+1]),
      .r_out    (sc_r[j+1]),
      .side_out (sc_side[j+1])
    );
  end

  // divider row: quotient of (|I| << F) + mag/2 by mag
  hs_t            dc_hs    [W+2];
  logic           dc_ready [W+2];
  logic [2*W:0]   dc_rem   [W+2];
  logic [W:0]     dc_q     [W+2];
  logic [W-1:0]   dc_mag   [W+2];
  logic [2*W-1:0] dc_side  [W+2];
  logic [W-1:0]   root;
  logic [W-1:0]   root_i;
  logic [W-1:0]   root_ai;

  assign root    = sc_r[W][W-1:0];
  assign root_i  = sc_side[W][W-1:0];
  assign root_ai = root_i[W-1] ? ~root_i + 1'b1 : root_i;

  assign sc_ready[W]    = dc_ready[0];
  assign dc_hs[0]       = sc_hs[W];
  assign dc_rem[0]      = ((2*W+1)'(root_ai) << F) + (2*W+1)'(root >> 1);
  assign dc_q[0]        = '0;
  assign dc_mag[0]      = root;
  assign dc_side[0]     = sc_side[W];

  for (genvar j = 0; j <= W; j++) begin : g_div
    cec_div_cell #(.W(W), .K(W-j)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up       (dc_hs[j]),
      .up_ready (dc_ready[j]),
      .rem_in   (dc_rem[j]),
      .q_in     (dc_q[j]),
      .mag_in   (dc_mag[j]),
      .side_in  (dc_side[j]),
      .dn       (dc_hs[j+1]),
      .dn_ready (dc_ready[j+1]),
      .rem_out  (dc_rem[j+1]),
      .q_out    (dc_q[j+1]),
      .mag_out  (dc_mag[j+1]),
      .side_out (dc_side[j+1])
    );
  end

  // output stage: choose branch and saturate
  logic [W-1:0]  fi, fq, fai;
  logic          fneg;
  logic [MW-1:0] limit_prod;
  logic          clip;
  logic [MW-1:0] scaled;
  logic [MW-1:0] val;
  logic [W-1:0]  res_i;
  logic [W-1:0]  out_i, out_q;

  assign fi   = dc_side[W+1][W-1:0];
  assign fq   = dc_side[W+1][2*W-1:W];
  assign fneg = fi[W-1];
  assign fai  = fneg ? ~fi + 1'b1 : fi;

  assign limit_prod = MW'(linear_gain) * MW'(dc_mag[W+1]);
  assign clip       = limit_prod > (MW'(1) << (GAIN_FRAC + F));
  assign scaled     = (MW'(fai) * MW'(linear_gain) + (MW'(1) << (GAIN_FRAC - 1))) >> GAIN_FRAC;
  assign val        = clip ? MW'(dc_q[W+1]) : scaled;

  always_comb begin
    if (fneg) begin
      res_i = (val > (MW'(1) << F)) ? {1'b1, {F{1'b0}}} : W'(~val + 1'b1);
    end else begin
      res_i = (val > ((MW'(1) << F) - 1'b1)) ? {1'b0, {F{1'b1}}} : val[W-1:0];
    end
  end

  assign dc_ready[W+1] = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (dc_ready[W+1]) begin
      m_tvalid <= dc_hs[W+1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dc_hs[W+1].valid && dc_ready[W+1]) begin
      out_i <= run_enable ? res_i : fi;
      out_q <= run_enable ? '0 : fq;
    end
  end

  assign m_tdata = TW'({out_q, out_i});

endmodule

@@ verif/tb_top.sv @@
// testbench for the complex envelope clipper: random and corner samples checked against a predictor
`timescale 1ns / 100ps

class clip_scoreboard;
  logic [15:0] want_i[$];
  logic [15:0] want_q[$];
  bit          run_en;
  logic [15:0] gain;
  int          mismatches;

  function new();
    run_en = 0;
    gain = 16'd4096;
    mismatches = 0;
  endfunction

  function logic [15:0] saturate(bit neg, longint unsigned m);
    longint v;
    if (neg) begin
      if (m > 32768) m = 32768;
      v = -longint'(m);
    end else begin
      if (m > 32767) m = 32767;
      v = longint'(m);
    end
    return v[15:0];
  endfunction

  function longint unsigned isqrt(longint unsigned x);
    longint unsigned r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  // note one accepted sample word
  function void note_sample(logic [15:0] si, logic [15:0] sq);
    longint unsigned ai, aq, mag, q;
    if (!run_en) begin
      want_i.push_back(si);
      want_q.push_back(sq);
      return;
    end
    ai = si[15] ? 64'd65536 - 64'(si) : 64'(si);
    aq = sq[15] ? 64'd65536 - 64'(sq) : 64'(sq);
    mag = isqrt(ai * ai + aq * aq);
    if (gain * mag > (64'd1 << 27) && mag != 0)
      q = ((ai << 15) + (mag >> 1)) / mag;
    else
      q = (ai * gain + 2048) >> 12;
    want_i.push_back(saturate(si[15], q));
    want_q.push_back(16'd0);
  endfunction

  function void check_result(logic [15:0] oi, logic [15:0] oq);
    logic [15:0] ei, eq;
    if (want_i.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected word: out_i %h out_q %h", oi, oq);
      return;
    end
    ei = want_i.pop_front();
    eq = want_q.pop_front();
    if (oi !== ei || oq !== eq) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected i %h q %h, got i %h q %h", ei, eq, oi, oq);
    end
  endfunction
endclass

module tb_top;
  import cec_pkg::*;

  localparam int LATENCY = 35;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;
  logic cfg_we = 0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_RUN_ENABLE;
  logic [GAIN_BITS-1:0] cfg_data = '0;

  int send_idle = 0;
  int recv_idle = 0;
  clip_scoreboard board;

  complex_envelope_clipper DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver with random stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_result(m_tdata[15:0], m_tdata[31:16]);
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_RUN_ENABLE) board.run_en = val[0];
    else board.gain = val;
  endtask

  task automatic send_word(logic [15:0] si, logic [15:0] sq);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {sq, si};
    do @(posedge clk); while (!s_tready);
    board.note_sample(si, sq);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.want_i.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] gains[6];
    gains = '{16'd4096, 16'd0, 16'hffff, 16'd1, 16'd8192, 16'd2048};
    board = new();
    repeat (2) @(posedge clk);
    rst <= 0;
    send_idle = 22;
    recv_idle = 52;
    // bypass at reset settings
    send_word(16'h8000, 16'h7fff);
    send_word(16'h7fff, 16'h8000);
    send_word(16'h0000, 16'h0000);
    drain();
    write_reg(REG_RUN_ENABLE, 16'hfffe);  // upper bits dropped, stays off
    write_reg(REG_RUN_ENABLE, 16'd1);
    // zero magnitude, full scale, ties
    send_word(16'h0000, 16'h0000);
    send_word(16'h8000, 16'h8000);
    send_word(16'h8000, 16'h0000);
    send_word(16'h7fff, 16'h7fff);
    send_word(16'h0001, 16'h0000);
    send_word(16'hffff, 16'h0000);
    send_word(16'h4000, 16'h4000);
    send_word(16'h0000, 16'h7fff);
    drain();
    write_reg(REG_LINEAR_GAIN, 16'hffff);
    send_word(16'h0001, 16'h0001);
    send_word(16'h8000, 16'h0001);
    send_word(16'h0003, 16'hfffd);
    drain();
    write_reg(REG_LINEAR_GAIN, 16'h0000);
    send_word(16'h7fff, 16'h0000);
    send_word(16'h8000, 16'h1234);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        send_idle = 52;
        recv_idle = 22;
      end else if (ph == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(REG_RUN_ENABLE, (ph % 4 == 3) ? 16'd0 : 16'd1);
      write_reg(REG_LINEAR_GAIN, (ph < 6) ? gains[ph] : 16'($urandom));
      for (int n = 0; n < 100; n++) send_word(rand_sample(), rand_sample());
      drain();
    end
    if (board.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end
endmodule
